### rtl/lps_pkg.sv
`default_nettype none

package lps_pkg;

  localparam int SENSOR_COUNT = 8;
  localparam int SIDX_W       = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int WEIGHT_STEP  = 10;
  localparam int SUM_MAX      = WEIGHT_STEP * SENSOR_COUNT * (SENSOR_COUNT + 1) / 2;
  localparam int SUM_W        = $clog2(SUM_MAX + 1);
  localparam int CNT_W        = $clog2(SENSOR_COUNT + 1);
  localparam int DCNT_W       = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  localparam int POS_W  = 7;
  localparam int SPD_W  = 7;
  localparam int GAIN_W = 12;
  localparam int ERR_W  = 8;
  localparam int DIF_W  = 9;
  localparam int INT_W  = 24;
  localparam int PROD_W = GAIN_W + 1 + DIF_W;
  localparam int ACC_W  = 26;
  localparam int FRAC_W = 6;
  localparam int TD_W   = ACC_W - FRAC_W;
  localparam int SD_W   = TD_W + 1;
  localparam int OUT_W  = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int ANGLE_MAX = 90;
  localparam int DRIVE_MAX = 100;

  localparam logic [POS_W-1:0]  SETPOINT_RST   = POS_W'(45);
  localparam logic [SPD_W-1:0]  BASE_SPEED_RST = SPD_W'(95);
  localparam logic [GAIN_W-1:0] SERVO_KP_RST   = GAIN_W'(118);
  localparam logic [GAIN_W-1:0] SERVO_KI_RST   = GAIN_W'(0);
  localparam logic [GAIN_W-1:0] SERVO_KD_RST   = GAIN_W'(640);
  localparam logic [GAIN_W-1:0] DRIVE_KP_RST   = GAIN_W'(230);
  localparam logic [GAIN_W-1:0] DRIVE_KI_RST   = GAIN_W'(0);
  localparam logic [GAIN_W-1:0] DRIVE_KD_RST   = GAIN_W'(192);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT   = 3'd0,
    CFG_BASE_SPEED = 3'd1,
    CFG_SERVO_KP   = 3'd2,
    CFG_SERVO_KI   = 3'd3,
    CFG_SERVO_KD   = 3'd4,
    CFG_DRIVE_KP   = 3'd5,
    CFG_DRIVE_KI   = 3'd6,
    CFG_DRIVE_KD   = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [POS_W-1:0]  setpoint;
    logic [SPD_W-1:0]  base_speed;
    logic [GAIN_W-1:0] servo_kp;
    logic [GAIN_W-1:0] servo_ki;
    logic [GAIN_W-1:0] servo_kd;
    logic [GAIN_W-1:0] drive_kp;
    logic [GAIN_W-1:0] drive_ki;
    logic [GAIN_W-1:0] drive_kd;
  } cfg_t;

  typedef enum logic {
    ALU_DIV = 1'b0,
    ALU_MAC = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e                  op;
    logic signed [ACC_W-1:0]  acc;
    logic [GAIN_W-1:0]        mul_a;
    logic signed [DIF_W-1:0]  mul_b;
    logic [CNT_W-1:0]         rem;
    logic [SUM_W-1:0]         dvd;
    logic [CNT_W-1:0]         den;
  } alu_req_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] mac;
    logic [CNT_W-1:0]        rem;
    logic [SUM_W-1:0]        dvd;
  } alu_rsp_t;

  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic signed [OUT_W-1:0] angle;
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] right;
  } res_t;

  // Sensor idx dark (active low); indices off the array never count.
  function automatic logic dark(logic [SENSOR_COUNT-1:0] bits, int idx);
    if (idx >= 0 && idx < SENSOR_COUNT) begin
      return ~bits[SIDX_W'(idx)];
    end
    return 1'b0;
  endfunction

endpackage

`default_nettype wire

### rtl/lps_alu.sv
`default_nettype none

// Shared unit: one restoring-division step or one signed multiply-accumulate.
module lps_alu (
  input  wire lps_pkg::alu_req_t req_i,
  output lps_pkg::alu_rsp_t      rsp_o
);

  logic [lps_pkg::CNT_W:0]                 shifted;
  logic [lps_pkg::CNT_W:0]                 trial;
  logic                                    q_bit;
  logic signed [lps_pkg::PROD_W-1:0]       prod;
  logic signed [lps_pkg::ACC_W-1:0]        mac;

  assign shifted = {req_i.rem, req_i.dvd[lps_pkg::SUM_W-1]};
  assign q_bit   = (shifted >= {1'b0, req_i.den});
  assign trial   = shifted - {1'b0, req_i.den};

  assign prod = $signed({1'b0, req_i.mul_a}) * $signed(req_i.mul_b);
  assign mac  = $signed(req_i.acc) + lps_pkg::ACC_W'(prod);

  always_comb begin
    rsp_o = '0;
    unique case (req_i.op)
      lps_pkg::ALU_DIV: begin
        rsp_o.mac = req_i.acc;
        rsp_o.rem = q_bit ? trial[lps_pkg::CNT_W-1:0] : shifted[lps_pkg::CNT_W-1:0];
        rsp_o.dvd = {req_i.dvd[lps_pkg::SUM_W-2:0], q_bit};
      end
      lps_pkg::ALU_MAC: begin
        rsp_o.mac = mac;
        rsp_o.rem = req_i.rem;
        rsp_o.dvd = req_i.dvd;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/lps_seq.sv
`default_nettype none

module lps_seq (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  start_i,
  input  wire [lps_pkg::SENSOR_COUNT-1:0]      bits_i,
  input  wire lps_pkg::cfg_t                   cfg_i,
  output logic                                 idle_o,
  output logic                                 res_valid_o,
  input  wire                                  res_ready_i,
  output lps_pkg::res_t                        res_o
);

  typedef enum logic [14:0] {
    ST_IDLE   = 15'h0001,
    ST_PREP   = 15'h0002,
    ST_DIV    = 15'h0004,
    ST_POS    = 15'h0008,
    ST_SINT   = 15'h0010,
    ST_SPROP  = 15'h0020,
    ST_SDER   = 15'h0040,
    ST_SOUT   = 15'h0080,
    ST_DINT   = 15'h0100,
    ST_DPROP  = 15'h0200,
    ST_DDER   = 15'h0400,
    ST_DTRUNC = 15'h0800,
    ST_DLEFT  = 15'h1000,
    ST_DRIGHT = 15'h2000,
    ST_DONE   = 15'h4000
  } state_e;

  localparam int N     = lps_pkg::SENSOR_COUNT;
  localparam int L     = N - 1;
  localparam int ACC_W = lps_pkg::ACC_W;
  localparam int TD_W  = lps_pkg::TD_W;
  localparam int SD_W  = lps_pkg::SD_W;
  localparam int OUT_W = lps_pkg::OUT_W;
  localparam int INT_W = lps_pkg::INT_W;

  localparam logic signed [ACC_W-1:0] ROUND_ADJ = ACC_W'((1 << lps_pkg::FRAC_W) - 1);
  localparam logic signed [ACC_W-1:0] INT_HI    = ACC_W'((1 << (INT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] INT_LO    = -INT_HI - ACC_W'(1);
  localparam logic signed [TD_W-1:0]  ANG_HI    = TD_W'(lps_pkg::ANGLE_MAX);
  localparam logic signed [TD_W-1:0]  ANG_LO    = -ANG_HI;
  localparam logic signed [SD_W-1:0]  DRV_HI    = SD_W'(lps_pkg::DRIVE_MAX);
  localparam logic signed [SD_W-1:0]  DRV_LO    = -DRV_HI;

  // Q.6 to integer, truncating toward zero
  function automatic logic signed [TD_W-1:0] trunc_q6(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] adj;
    adj = v[ACC_W-1] ? v + ROUND_ADJ : v;
    return TD_W'(adj >>> lps_pkg::FRAC_W);
  endfunction

  function automatic logic signed [INT_W-1:0] sat_int(logic signed [ACC_W-1:0] v);
    if (v > INT_HI) begin
      return INT_W'(INT_HI);
    end else if (v < INT_LO) begin
      return INT_W'(INT_LO);
    end
    return INT_W'(v);
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_angle(logic signed [TD_W-1:0] v);
    if (v > ANG_HI) begin
      return OUT_W'(ANG_HI);
    end else if (v < ANG_LO) begin
      return OUT_W'(ANG_LO);
    end
    return OUT_W'(v);
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_drive(logic signed [SD_W-1:0] v);
    if (v > DRV_HI) begin
      return OUT_W'(DRV_HI);
    end else if (v < DRV_LO) begin
      return OUT_W'(DRV_LO);
    end
    return OUT_W'(v);
  endfunction

  state_e state_q, state_d;

  // control state
  logic [lps_pkg::POS_W-1:0]         last_pos_q;
  logic signed [lps_pkg::ERR_W-1:0]  prev_err_q;
  logic signed [INT_W-1:0]           si_q;
  logic signed [INT_W-1:0]           di_q;

  // working registers
  logic [N-1:0]                      bits_q;
  logic [lps_pkg::SUM_W-1:0]         dvd_q;
  logic [lps_pkg::CNT_W-1:0]         rem_q;
  logic [lps_pkg::CNT_W-1:0]         cnt_q;
  logic [lps_pkg::DCNT_W-1:0]        dcnt_q;
  logic                              hold_q;
  logic                              curve_q;
  logic [lps_pkg::POS_W-1:0]         pos_q;
  logic signed [lps_pkg::DIF_W-1:0]  dif_q;
  logic [lps_pkg::SPD_W-1:0]         speed_q;
  logic signed [ACC_W-1:0]           acc_q;
  logic signed [OUT_W-1:0]           angle_q;
  logic signed [TD_W-1:0]            td_q;
  logic signed [OUT_W-1:0]           left_q;
  logic signed [OUT_W-1:0]           right_q;

  logic [lps_pkg::SUM_W-1:0]         sum_c;
  logic [lps_pkg::CNT_W-1:0]         cnt_c;
  logic                              hold_c;
  logic                              curve_c;
  logic [lps_pkg::SUM_W+lps_pkg::POS_W-1:0] quot_ext;
  logic [lps_pkg::POS_W-1:0]         pos_c;
  logic signed [lps_pkg::ERR_W-1:0]  err_c;
  logic signed [lps_pkg::DIF_W-1:0]  dif_c;
  logic [lps_pkg::SPD_W-1:0]         speed_c;
  logic signed [SD_W-1:0]            speed_s;
  logic signed [SD_W-1:0]            lsum_c;
  logic signed [SD_W-1:0]            rsum_c;
  logic                              lovr_c;
  logic signed [OUT_W-1:0]           spd_clip;
  logic                              zero_err;

  lps_pkg::alu_req_t alu_req;
  lps_pkg::alu_rsp_t alu_rsp;

  lps_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // dark-sensor weights; leftmost sensor carries the smallest weight
  always_comb begin
    sum_c = '0;
    cnt_c = '0;
    for (int i = 0; i < N; i++) begin
      if (lps_pkg::dark(bits_q, L - i)) begin
        sum_c = sum_c + lps_pkg::SUM_W'(lps_pkg::WEIGHT_STEP * (i + 1));
        cnt_c = cnt_c + lps_pkg::CNT_W'(1);
      end
    end
  end

  assign hold_c = (lps_pkg::dark(bits_q, L) && lps_pkg::dark(bits_q, L - 1)) ||
                  (lps_pkg::dark(bits_q, 0) && lps_pkg::dark(bits_q, 1)) ||
                  (lps_pkg::dark(bits_q, L) && lps_pkg::dark(bits_q, 0));
  assign curve_c = lps_pkg::dark(bits_q, L - 1) || lps_pkg::dark(bits_q, L - 2) ||
                   lps_pkg::dark(bits_q, 2) || lps_pkg::dark(bits_q, 1);

  assign quot_ext = {{lps_pkg::POS_W{1'b0}}, dvd_q};
  assign pos_c    = hold_q ? last_pos_q :
                    (cnt_q == '0) ? '0 : quot_ext[lps_pkg::POS_W-1:0];
  assign err_c    = lps_pkg::ERR_W'({1'b0, pos_c}) - lps_pkg::ERR_W'({1'b0, cfg_i.setpoint});
  assign dif_c    = lps_pkg::DIF_W'(err_c) - lps_pkg::DIF_W'(prev_err_q);
  assign speed_c  = curve_q ? (cfg_i.base_speed >> 1) : cfg_i.base_speed;

  assign speed_s  = SD_W'($signed({1'b0, speed_q}));
  assign lsum_c   = speed_s + SD_W'(td_q);
  assign rsum_c   = speed_s - SD_W'(td_q);
  assign lovr_c   = (lsum_c > DRV_HI) || (lsum_c < DRV_LO);
  assign spd_clip = (speed_q > lps_pkg::SPD_W'(lps_pkg::DRIVE_MAX)) ?
                    OUT_W'(lps_pkg::DRIVE_MAX) : OUT_W'(speed_q);
  // after the position step prev_err_q holds this transaction's error
  assign zero_err = (prev_err_q == '0);

  always_comb begin
    alu_req       = '0;
    alu_req.op    = lps_pkg::ALU_MAC;
    alu_req.rem   = rem_q;
    alu_req.dvd   = dvd_q;
    alu_req.den   = cnt_q;
    unique case (state_q)
      ST_DIV: begin
        alu_req.op = lps_pkg::ALU_DIV;
      end
      ST_SINT: begin
        alu_req.acc   = ACC_W'(si_q);
        alu_req.mul_a = cfg_i.servo_ki;
        alu_req.mul_b = dif_q;
      end
      ST_SPROP: begin
        alu_req.acc   = ACC_W'(si_q);
        alu_req.mul_a = cfg_i.servo_kp;
        alu_req.mul_b = lps_pkg::DIF_W'(prev_err_q);
      end
      ST_SDER: begin
        alu_req.acc   = acc_q;
        alu_req.mul_a = cfg_i.servo_kd;
        alu_req.mul_b = dif_q;
      end
      ST_DINT: begin
        alu_req.acc   = ACC_W'(di_q);
        alu_req.mul_a = cfg_i.drive_ki;
        alu_req.mul_b = dif_q;
      end
      ST_DPROP: begin
        alu_req.acc   = ACC_W'(di_q);
        alu_req.mul_a = cfg_i.drive_kp;
        alu_req.mul_b = lps_pkg::DIF_W'(prev_err_q);
      end
      ST_DDER: begin
        alu_req.acc   = acc_q;
        alu_req.mul_a = cfg_i.drive_kd;
        alu_req.mul_b = dif_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_PREP;
      ST_PREP:   state_d = ST_DIV;
      ST_DIV:    if (dcnt_q == '0) state_d = ST_POS;
      ST_POS:    state_d = ST_SINT;
      ST_SINT:   state_d = ST_SPROP;
      ST_SPROP:  state_d = ST_SDER;
      ST_SDER:   state_d = ST_SOUT;
      ST_SOUT:   state_d = ST_DINT;
      ST_DINT:   state_d = ST_DPROP;
      ST_DPROP:  state_d = ST_DDER;
      ST_DDER:   state_d = ST_DTRUNC;
      ST_DTRUNC: state_d = ST_DLEFT;
      ST_DLEFT:  state_d = ST_DRIGHT;
      ST_DRIGHT: state_d = ST_DONE;
      ST_DONE:   if (res_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      last_pos_q <= lps_pkg::SETPOINT_RST;
      prev_err_q <= '0;
      si_q       <= '0;
      di_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_POS) begin
        last_pos_q <= pos_c;
        prev_err_q <= err_c;
      end
      if (state_q == ST_SINT) begin
        si_q <= sat_int(alu_rsp.mac);
      end
      if (state_q == ST_SOUT && zero_err) begin
        si_q <= '0;
      end
      if (state_q == ST_DINT) begin
        di_q <= sat_int(alu_rsp.mac);
      end
      if ((state_q == ST_DLEFT && lovr_c) || (state_q == ST_DRIGHT && zero_err)) begin
        di_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) bits_q <= bits_i;
      end
      ST_PREP: begin
        dvd_q   <= sum_c;
        cnt_q   <= cnt_c;
        rem_q   <= '0;
        dcnt_q  <= lps_pkg::DCNT_W'(lps_pkg::SUM_W - 1);
        hold_q  <= hold_c;
        curve_q <= curve_c;
      end
      ST_DIV: begin
        rem_q  <= alu_rsp.rem;
        dvd_q  <= alu_rsp.dvd;
        dcnt_q <= dcnt_q - lps_pkg::DCNT_W'(1);
      end
      ST_POS: begin
        pos_q   <= pos_c;
        dif_q   <= dif_c;
        speed_q <= speed_c;
      end
      ST_SPROP, ST_SDER, ST_DPROP, ST_DDER: begin
        acc_q <= alu_rsp.mac;
      end
      ST_SOUT: begin
        angle_q <= clamp_angle(trunc_q6(acc_q));
      end
      ST_DTRUNC: begin
        td_q <= trunc_q6(acc_q);
      end
      ST_DLEFT: begin
        left_q <= clamp_drive(lsum_c);
      end
      ST_DRIGHT: begin
        if (zero_err) begin
          left_q  <= spd_clip;
          right_q <= spd_clip;
        end else begin
          right_q <= clamp_drive(rsum_c);
        end
      end
      default: ;
    endcase
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = '{pos: pos_q, angle: angle_q, left: left_q, right: right_q};

endmodule

`default_nettype wire

### rtl/line_position_pid_steering.sv
// Line follower steering: each sensor transaction gives the dark-sensor centroid
// position, a PD(I) servo angle (clamped to +/-90) and left/right drives (clamped
// to +/-100). The block takes no new transaction until the current one is done:
// one shared divide-step / multiply-accumulate unit runs the 9-step centroid
// division and then six multiply-accumulates, one per cycle, under a small
// sequencer. The result sits in an output register, so the next transaction can
// start while it waits. Configuration is taken at any time but should only be
// written while the block is idle.
`default_nettype none

module line_position_pid_steering (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,

  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire [lps_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire [lps_pkg::CFG_DATA_W-1:0]         cfg_data_i,

  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire [lps_pkg::SENSOR_COUNT-1:0]       sensor_bits_i,

  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [lps_pkg::POS_W-1:0]             line_position_o,
  output logic signed [lps_pkg::OUT_W-1:0]      servo_angle_o,
  output logic signed [lps_pkg::OUT_W-1:0]      left_drive_o,
  output logic signed [lps_pkg::OUT_W-1:0]      right_drive_o
);

  lps_pkg::cfg_t cfg_q;
  lps_pkg::res_t res;
  lps_pkg::res_t out_q;
  logic          seq_idle;
  logic          res_valid;
  logic          res_ready;
  logic          out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint   <= lps_pkg::SETPOINT_RST;
      cfg_q.base_speed <= lps_pkg::BASE_SPEED_RST;
      cfg_q.servo_kp   <= lps_pkg::SERVO_KP_RST;
      cfg_q.servo_ki   <= lps_pkg::SERVO_KI_RST;
      cfg_q.servo_kd   <= lps_pkg::SERVO_KD_RST;
      cfg_q.drive_kp   <= lps_pkg::DRIVE_KP_RST;
      cfg_q.drive_ki   <= lps_pkg::DRIVE_KI_RST;
      cfg_q.drive_kd   <= lps_pkg::DRIVE_KD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lps_pkg::cfg_idx_e'(cfg_index_i))
        lps_pkg::CFG_SETPOINT:   cfg_q.setpoint   <= cfg_data_i[lps_pkg::POS_W-1:0];
        lps_pkg::CFG_BASE_SPEED: cfg_q.base_speed <= cfg_data_i[lps_pkg::SPD_W-1:0];
        lps_pkg::CFG_SERVO_KP:   cfg_q.servo_kp   <= cfg_data_i[lps_pkg::GAIN_W-1:0];
        lps_pkg::CFG_SERVO_KI:   cfg_q.servo_ki   <= cfg_data_i[lps_pkg::GAIN_W-1:0];
        lps_pkg::CFG_SERVO_KD:   cfg_q.servo_kd   <= cfg_data_i[lps_pkg::GAIN_W-1:0];
        lps_pkg::CFG_DRIVE_KP:   cfg_q.drive_kp   <= cfg_data_i[lps_pkg::GAIN_W-1:0];
        lps_pkg::CFG_DRIVE_KI:   cfg_q.drive_ki   <= cfg_data_i[lps_pkg::GAIN_W-1:0];
        lps_pkg::CFG_DRIVE_KD:   cfg_q.drive_kd   <= cfg_data_i[lps_pkg::GAIN_W-1:0];
      endcase
    end
  end

  assign in_stall_o = !seq_idle;

  lps_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && !in_stall_o),
    .bits_i      (sensor_bits_i),
    .cfg_i       (cfg_q),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output slot frees up in the same cycle its transaction completes
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_position_o = out_q.pos;
  assign servo_angle_o   = out_q.angle;
  assign left_drive_o    = out_q.left;
  assign right_drive_o   = out_q.right;

endmodule

`default_nettype wire
